// File: hdl/bgc_pkg.sv
// Shared types, constants and codes for the button gesture classifier.
`timescale 1ns / 1ps

package bgc_pkg;

  // Field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CountW   = 2;
  localparam int unsigned EffectW  = 8;
  localparam int unsigned CountIncW = CountW + 1;

  // Configuration reset values (milliseconds)
  localparam logic [CfgW-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [CfgW-1:0] CLICK_WINDOW_RST = 16'd450;
  localparam logic [CfgW-1:0] HOLD_RST         = 16'd900;

  // Haptic effect numbers
  localparam logic [EffectW-1:0] FX_NONE          = 8'h00;
  localparam logic [EffectW-1:0] FX_ROUTINE_START = 8'h01;
  localparam logic [EffectW-1:0] FX_EMERGENCY     = 8'h2F;
  localparam logic [EffectW-1:0] FX_CANCEL        = 8'h0C;
  localparam logic [EffectW-1:0] FX_WAKE          = 8'h0A;

  // Click counts that trigger a gesture
  localparam logic [CountIncW-1:0] CLICKS_START     = 3'd1;
  localparam logic [CountIncW-1:0] CLICKS_WAKE      = 3'd2;
  localparam logic [CountIncW-1:0] CLICKS_EMERGENCY = 3'd3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_HOLD         = 2'd2
  } cfg_reg_e;

  // Gesture codes
  typedef enum logic [2:0] {
    EV_NONE            = 3'd0,
    EV_ROUTINE_START   = 3'd1,
    EV_EMERGENCY_START = 3'd2,
    EV_ROUTINE_CANCEL  = 3'd3,
    EV_WAKE            = 3'd4
  } gesture_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] click_window_ms;
    logic [CfgW-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  last_edge_time;
    logic [TimeW-1:0]  press_start_time;
    logic              press_active;
    logic [CountW-1:0] click_count;
    logic [TimeW-1:0]  last_click_time;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             button_level;
    logic             link_connected;
    logic             device_claimed;
  } edge_t;

  typedef struct packed {
    logic               edge_accepted;
    gesture_e           gesture_event;
    logic [EffectW-1:0] haptic_effect;
    logic               advertise_setup;
  } result_t;

endpackage

// File: hdl/bgc_edge_if.sv
// Valid/ready channel carrying one button edge event.
`timescale 1ns / 1ps

interface bgc_edge_if import bgc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] time_ms;
  logic             button_level;
  logic             link_connected;
  logic             device_claimed;

  modport source (
    output valid, time_ms, button_level, link_connected, device_claimed,
    input  ready
  );

  modport sink (
    input  valid, time_ms, button_level, link_connected, device_claimed,
    output ready
  );
endinterface

// File: hdl/bgc_gesture_if.sv
// Valid/ready channel carrying one classification result.
`timescale 1ns / 1ps

interface bgc_gesture_if import bgc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               edge_accepted;
  logic [2:0]         gesture_event;
  logic [EffectW-1:0] haptic_effect;
  logic               advertise_setup;

  modport source (
    output valid, edge_accepted, gesture_event, haptic_effect, advertise_setup,
    input  ready
  );

  modport sink (
    input  valid, edge_accepted, gesture_event, haptic_effect, advertise_setup,
    output ready
  );
endinterface

// File: hdl/bgc_cfg_regs.sv
// Configuration registers for debounce, click window and hold times.
`timescale 1ns / 1ps

module bgc_cfg_regs import bgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  // Decode the index and update the addressed register; ignore unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DEBOUNCE_RST;
      cfg_q.click_window_ms <= CLICK_WINDOW_RST;
      cfg_q.hold_ms         <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_wdata_i;
        REG_CLICK_WINDOW: cfg_q.click_window_ms <= cfg_wdata_i;
        REG_HOLD:         cfg_q.hold_ms         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/bgc_classify.sv
// Single-step classification of one edge: debounce, press tracking, click counting.
`timescale 1ns / 1ps

module bgc_classify import bgc_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  edge_t   edge_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [TimeW-1:0]     edge_gap;
  logic [TimeW-1:0]     press_len;
  logic [TimeW-1:0]     click_gap;
  logic                 bounce;
  logic                 is_hold;
  logic                 window_over;
  logic [CountW-1:0]    cnt_live;
  logic [CountIncW-1:0] cnt_inc;

  // Elapsed times, all modulo 2^32
  assign edge_gap  = edge_i.time_ms - state_i.last_edge_time;
  assign press_len = edge_i.time_ms - state_i.press_start_time;
  assign click_gap = edge_i.time_ms - state_i.last_click_time;

  assign bounce      = edge_gap < {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms};
  assign is_hold     = press_len >= {{(TimeW-CfgW){1'b0}}, cfg_i.hold_ms};
  assign window_over = click_gap >= {{(TimeW-CfgW){1'b0}}, cfg_i.click_window_ms};

  // Expire the click count lazily when the window has passed
  assign cnt_live = ((state_i.click_count != '0) && window_over) ? '0 : state_i.click_count;
  assign cnt_inc  = {1'b0, cnt_live} + CountIncW'(1);

  // Classify the edge and work out the next state
  always_comb begin
    state_o                  = state_i;
    result_o.edge_accepted   = 1'b0;
    result_o.gesture_event   = EV_NONE;
    result_o.haptic_effect   = FX_NONE;
    result_o.advertise_setup = 1'b0;

    if (!bounce) begin
      result_o.edge_accepted = 1'b1;
      state_o.last_edge_time = edge_i.time_ms;

      if (edge_i.button_level) begin
        state_o.press_active     = 1'b1;
        state_o.press_start_time = edge_i.time_ms;
      end else if (state_i.press_active) begin
        state_o.press_active = 1'b0;
        if (is_hold) begin
          // Hold: cancel while connected, ignore otherwise
          state_o.click_count = '0;
          if (edge_i.link_connected) begin
            result_o.gesture_event = EV_ROUTINE_CANCEL;
            result_o.haptic_effect = FX_CANCEL;
          end
        end else begin
          state_o.last_click_time = edge_i.time_ms;
          if (edge_i.link_connected) begin
            if (cnt_inc >= CLICKS_EMERGENCY) begin
              state_o.click_count    = '0;
              result_o.gesture_event = EV_EMERGENCY_START;
              result_o.haptic_effect = FX_EMERGENCY;
            end else begin
              state_o.click_count = cnt_inc[CountW-1:0];
              if (cnt_inc == CLICKS_START) begin
                result_o.gesture_event = EV_ROUTINE_START;
                result_o.haptic_effect = FX_ROUTINE_START;
              end
            end
          end else begin
            if (cnt_inc >= CLICKS_WAKE) begin
              state_o.click_count      = '0;
              result_o.gesture_event   = EV_WAKE;
              result_o.haptic_effect   = FX_WAKE;
              result_o.advertise_setup = ~edge_i.device_claimed;
            end else begin
              state_o.click_count = cnt_inc[CountW-1:0];
            end
          end
        end
      end
    end
  end

endmodule

// File: hdl/button_gesture_classifier.sv
// Top level of the button gesture classifier: input register, state, result register.
`timescale 1ns / 1ps

// Each transferred edge event lands in an input register, is classified against
// the held press/click state once the result register is free or being drained,
// and its result is then registered in the output register. One event can be
// taken every clock while the sink keeps the result register drained. The
// throughput is set by the read-modify-write of the gesture state. Every accepted
// edge gives exactly one result (a debounced edge reports all-zero fields).
// Configuration writes should be made only while no event is in flight.

module button_gesture_classifier import bgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  bgc_edge_if.sink           edge_in,
  bgc_gesture_if.source      gest_out
);

  cfg_t    cfg;
  edge_t   in_q;
  logic    in_vld_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t out_q;
  logic    out_vld_q;
  logic    step_fire;
  logic    in_ready;
  logic    in_load;

  bgc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bgc_classify u_classify (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .edge_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Advance when the result register is free or being drained
  assign step_fire     = in_vld_q && (!out_vld_q || gest_out.ready);
  assign in_ready      = !in_vld_q || step_fire;
  assign in_load       = edge_in.valid && in_ready;
  assign edge_in.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_load) begin
      in_vld_q <= 1'b1;
    end else if (step_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q.time_ms        <= edge_in.time_ms;
      in_q.button_level   <= edge_in.button_level;
      in_q.link_connected <= edge_in.link_connected;
      in_q.device_claimed <= edge_in.device_claimed;
    end
  end

  // Gesture state, updated once per classified edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_fire) begin
      out_vld_q <= 1'b1;
    end else if (gest_out.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= res_d;
    end
  end

  assign gest_out.valid           = out_vld_q;
  assign gest_out.edge_accepted   = out_q.edge_accepted;
  assign gest_out.gesture_event   = out_q.gesture_event;
  assign gest_out.haptic_effect   = out_q.haptic_effect;
  assign gest_out.advertise_setup = out_q.advertise_setup;

  // A dropped edge never carries a gesture or an effect
  a_drop_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gest_out.valid && !gest_out.edge_accepted) |->
      (gest_out.gesture_event == EV_NONE && gest_out.haptic_effect == FX_NONE))
    else $error("dropped edge reported a gesture");

  // The click count is cleared before it can reach three
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.click_count != 2'd3)
    else $error("click count reached an unreachable value");

  // Every classified edge shows up in the result register next cycle
  a_step_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> gest_out.valid)
    else $error("classified edge lost before the result register");

  // Setup advertising is only flagged on a wake gesture
  a_setup_only_on_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gest_out.valid && gest_out.advertise_setup) |-> (gest_out.gesture_event == EV_WAKE))
    else $error("advertise_setup set outside a wake gesture");

endmodule
